// ===== rtl/core/ccc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types and constants for the 11-bit coefficient compress codec.
// ----------------------------------------------------------------------------
package ccc_pkg;

  localparam int LANES       = 8;
  localparam int CODE_W      = 11;
  localparam int COEF_W      = 13;
  localparam int HALF_W      = 12;
  localparam int RECIP_W     = 28;
  localparam int RECIP_SHIFT = 29;
  localparam int PACK_W      = LANES * CODE_W;
  localparam int PACK_LO_W   = 64;
  localparam int PACK_HI_W   = PACK_W - PACK_LO_W;
  localparam int DIV_W       = COEF_W + CODE_W + 1;     // (c << 11) + q/2
  localparam int PROD_W      = RECIP_SHIFT + CODE_W;    // bits kept from a lane
  localparam int EXP_W       = CODE_W + COEF_W;         // v * q
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam logic [EXP_W-1:0]   DECOMP_ROUND  = EXP_W'(1024);
  localparam logic [COEF_W-1:0]  MODULUS_RST   = COEF_W'(7681);
  localparam logic [HALF_W-1:0]  HALF_RST      = HALF_W'(3840);
  localparam logic [RECIP_W-1:0] RECIP_RST     = RECIP_W'(69896);

  localparam logic [1:0] REG_MODULUS    = 2'd0;
  localparam logic [1:0] REG_HALF       = 2'd1;
  localparam logic [1:0] REG_RECIPROCAL = 2'd2;

  typedef enum logic {
    OP_COMPRESS   = 1'b0,
    OP_DECOMPRESS = 1'b1
  } op_t;

  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic [COEF_W-1:0]  modulus;
    logic [HALF_W-1:0]  modulus_half;
    logic [RECIP_W-1:0] reciprocal;
  } cfg_t;

endpackage

// ===== rtl/core/coefficient_compress_codec_11bit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coefficient_compress_codec_11bit
// Compress/pack and unpack/decompress of eight-coefficient groups, eight
// multiplier lanes in parallel followed by a merge stage.
// ----------------------------------------------------------------------------
//  channel  | handshake                        | payload
//  ---------+----------------------------------+------------------------------
//  input    | start & !busy                    | in_req_type, in_coef_0..7,
//           |                                  | in_packed_low/high
//  result   | out_valid, one cycle per word    | out_coef_0..7,
//           |                                  | out_packed_low/high
//  config   | psel & penable & pwrite (pready) | paddr, pwdata, prdata
//
// One word is taken every cycle; the result word is registered in the lane
// multiplier register, then in the merge register.
// busy never rises, so start may be held high continuously.
// Synchronous reset clears the valid pipeline and loads the register
// defaults (modulus 7681, half 3840, reciprocal 69896).
// The receiver cannot stall: every out_valid word must be taken.
// ----------------------------------------------------------------------------
module coefficient_compress_codec_11bit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_req_type,
  input  logic [ccc_pkg::COEF_W-1:0]        in_coef_0,
  input  logic [ccc_pkg::COEF_W-1:0]        in_coef_1,
  input  logic [ccc_pkg::COEF_W-1:0]        in_coef_2,
  input  logic [ccc_pkg::COEF_W-1:0]        in_coef_3,
  input  logic [ccc_pkg::COEF_W-1:0]        in_coef_4,
  input  logic [ccc_pkg::COEF_W-1:0]        in_coef_5,
  input  logic [ccc_pkg::COEF_W-1:0]        in_coef_6,
  input  logic [ccc_pkg::COEF_W-1:0]        in_coef_7,
  input  logic [ccc_pkg::PACK_LO_W-1:0]     in_packed_low,
  input  logic [ccc_pkg::PACK_HI_W-1:0]     in_packed_high,
  output logic                              out_valid,
  output logic [ccc_pkg::COEF_W-1:0]        out_coef_0,
  output logic [ccc_pkg::COEF_W-1:0]        out_coef_1,
  output logic [ccc_pkg::COEF_W-1:0]        out_coef_2,
  output logic [ccc_pkg::COEF_W-1:0]        out_coef_3,
  output logic [ccc_pkg::COEF_W-1:0]        out_coef_4,
  output logic [ccc_pkg::COEF_W-1:0]        out_coef_5,
  output logic [ccc_pkg::COEF_W-1:0]        out_coef_6,
  output logic [ccc_pkg::COEF_W-1:0]        out_coef_7,
  output logic [ccc_pkg::PACK_LO_W-1:0]     out_packed_low,
  output logic [ccc_pkg::PACK_HI_W-1:0]     out_packed_high,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ccc_pkg::ADDR_W-1:0]        paddr,
  input  logic [ccc_pkg::DATA_W-1:0]        pwdata,
  output logic [ccc_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  ccc_pkg::cfg_t   cfg_r, cfg_nxt;
  logic            cfg_wr;
  logic [1:0]      reg_idx;

  logic            accept;
  logic            s1_valid_r;
  ccc_pkg::op_t    s1_op_r;
  ccc_pkg::op_t    in_op;
  logic [ccc_pkg::PACK_W-1:0] in_packed;
  ccc_pkg::coef_t  lane_coef [ccc_pkg::LANES];
  ccc_pkg::prod_t  lane_prod [ccc_pkg::LANES];
  ccc_pkg::coef_t  res_coef  [ccc_pkg::LANES];

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start & ~busy;
  assign in_op  = ccc_pkg::op_t'(in_req_type);

  // ---------------- configuration registers ----------------
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        ccc_pkg::REG_MODULUS:    cfg_nxt.modulus      = pwdata[ccc_pkg::COEF_W-1:0];
        ccc_pkg::REG_HALF:       cfg_nxt.modulus_half = pwdata[ccc_pkg::HALF_W-1:0];
        ccc_pkg::REG_RECIPROCAL: cfg_nxt.reciprocal   = pwdata[ccc_pkg::RECIP_W-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ccc_pkg::REG_MODULUS:    prdata = ccc_pkg::DATA_W'(cfg_r.modulus);
      ccc_pkg::REG_HALF:       prdata = ccc_pkg::DATA_W'(cfg_r.modulus_half);
      ccc_pkg::REG_RECIPROCAL: prdata = ccc_pkg::DATA_W'(cfg_r.reciprocal);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.modulus      <= ccc_pkg::MODULUS_RST;
      cfg_r.modulus_half <= ccc_pkg::HALF_RST;
      cfg_r.reciprocal   <= ccc_pkg::RECIP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------- lanes ----------------
  assign in_packed = {in_packed_high, in_packed_low};

  assign lane_coef[0] = in_coef_0;
  assign lane_coef[1] = in_coef_1;
  assign lane_coef[2] = in_coef_2;
  assign lane_coef[3] = in_coef_3;
  assign lane_coef[4] = in_coef_4;
  assign lane_coef[5] = in_coef_5;
  assign lane_coef[6] = in_coef_6;
  assign lane_coef[7] = in_coef_7;

  for (genvar k = 0; k < ccc_pkg::LANES; k++) begin : g_lane
    ccc_lane u_lane (
      .clk    (clk),
      .op     (in_op),
      .coef   (lane_coef[k]),
      .code   (in_packed[k*ccc_pkg::CODE_W +: ccc_pkg::CODE_W]),
      .cfg    (cfg_r),
      .prod_r (lane_prod[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r <= in_op;
  end

  // ---------------- merge ----------------
  ccc_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (s1_valid_r),
    .op          (s1_op_r),
    .prod        (lane_prod),
    .valid_r     (out_valid),
    .coef_r      (res_coef),
    .packed_lo_r (out_packed_low),
    .packed_hi_r (out_packed_high)
  );

  assign out_coef_0 = res_coef[0];
  assign out_coef_1 = res_coef[1];
  assign out_coef_2 = res_coef[2];
  assign out_coef_3 = res_coef[3];
  assign out_coef_4 = res_coef[4];
  assign out_coef_5 = res_coef[5];
  assign out_coef_6 = res_coef[6];
  assign out_coef_7 = res_coef[7];

endmodule

// ===== rtl/core/ccc_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_lane
// One coefficient lane: a single shared multiplier that forms either the
// reciprocal product for compression or v*q for decompression.
// ----------------------------------------------------------------------------
module ccc_lane (
  input  logic             clk,
  input  ccc_pkg::op_t     op,
  input  ccc_pkg::coef_t   coef,
  input  ccc_pkg::code_t   code,
  input  ccc_pkg::cfg_t    cfg,
  output ccc_pkg::prod_t   prod_r
);

  localparam int MUL_A_W = ccc_pkg::DIV_W;
  localparam int MUL_B_W = ccc_pkg::RECIP_W;

  logic [MUL_A_W-1:0]         div_in;
  logic [MUL_A_W-1:0]         mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic [MUL_A_W+MUL_B_W-1:0] full;
  ccc_pkg::prod_t             prod_nxt;

  always_comb begin
    div_in = {1'b0, coef, {ccc_pkg::CODE_W{1'b0}}}
           + MUL_A_W'(cfg.modulus_half);
    if (op == ccc_pkg::OP_DECOMPRESS) begin
      mul_a = MUL_A_W'(code);
      mul_b = MUL_B_W'(cfg.modulus);
    end else begin
      mul_a = div_in;
      mul_b = cfg.reciprocal;
    end
    full     = (MUL_A_W+MUL_B_W)'(mul_a) * (MUL_A_W+MUL_B_W)'(mul_b);
    prod_nxt = full[ccc_pkg::PROD_W-1:0];
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ===== rtl/core/ccc_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_merge
// Merge stage: pulls the code or rounded coefficient out of each lane
// product, packs codes into the 88-bit group and registers the result word.
// ----------------------------------------------------------------------------
module ccc_merge (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             valid,
  input  ccc_pkg::op_t                     op,
  input  ccc_pkg::prod_t                   prod [ccc_pkg::LANES],
  output logic                             valid_r,
  output ccc_pkg::coef_t                   coef_r [ccc_pkg::LANES],
  output logic [ccc_pkg::PACK_LO_W-1:0]    packed_lo_r,
  output logic [ccc_pkg::PACK_HI_W-1:0]    packed_hi_r
);

  logic [ccc_pkg::PACK_W-1:0]  packed_all;
  ccc_pkg::coef_t              coef_nxt [ccc_pkg::LANES];
  logic [ccc_pkg::EXP_W-1:0]   rounded  [ccc_pkg::LANES];
  logic [ccc_pkg::PACK_LO_W-1:0] packed_lo_nxt;
  logic [ccc_pkg::PACK_HI_W-1:0] packed_hi_nxt;

  always_comb begin
    packed_all = '0;
    for (int k = 0; k < ccc_pkg::LANES; k++) begin
      rounded[k] = prod[k][ccc_pkg::EXP_W-1:0] + ccc_pkg::DECOMP_ROUND;
      packed_all[k*ccc_pkg::CODE_W +: ccc_pkg::CODE_W] =
        prod[k][ccc_pkg::PROD_W-1:ccc_pkg::RECIP_SHIFT];
      coef_nxt[k] = '0;
      if (op == ccc_pkg::OP_DECOMPRESS) begin
        coef_nxt[k] = rounded[k][ccc_pkg::EXP_W-1:ccc_pkg::CODE_W];
      end
    end
    // drop the packed word on decompress
    if (op == ccc_pkg::OP_DECOMPRESS) begin
      packed_lo_nxt = '0;
      packed_hi_nxt = '0;
    end else begin
      packed_lo_nxt = packed_all[ccc_pkg::PACK_LO_W-1:0];
      packed_hi_nxt = packed_all[ccc_pkg::PACK_W-1:ccc_pkg::PACK_LO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid;
    end
  end

  always_ff @(posedge clk) begin
    coef_r      <= coef_nxt;
    packed_lo_r <= packed_lo_nxt;
    packed_hi_r <= packed_hi_nxt;
  end

endmodule
